FILE: rtl/sha1md_pkg.sv
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared types and constants of the SHA-1 message digest block.
// ----------------------------------------------------------------------------
package sha1md_pkg;

    // what a queued transaction asks the hash core to do
    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_END,
        KIND_BYTE_END
    } item_kind_t;

    typedef struct packed {
        logic [7:0] data;
        item_kind_t kind;
    } item_t;

    localparam int WORD_COUNT = 5;

    localparam logic [31:0] SHA1_IV [WORD_COUNT] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // round constant per group of 20 rounds
    function automatic logic [31:0] round_k(input logic [1:0] grp);
        logic [31:0] k;
        case (grp)
            2'd0:    k = 32'h5A827999;
            2'd1:    k = 32'h6ED9EBA1;
            2'd2:    k = 32'h8F1BBCDC;
            default: k = 32'hCA62C1D6;
        endcase
        return k;
    endfunction

endpackage

FILE: rtl/sha1_message_digest.sv
// ----------------------------------------------------------------------------
// sha1_message_digest
// SHA-1 of a byte stream; the digest comes out as five 32-bit words.
// ----------------------------------------------------------------------------
// Input channel s_axis: one transaction per message byte; tuser marks that
// tdata holds a byte, tlast marks the end of the message. A transaction with
// tlast and no byte ends the message without adding a byte (empty message).
// Output channel m_axis: five transactions per message, digest word 0 first,
// word number on tuser, tlast on word 4.
// Input transactions go into a queue (QUEUE_DEPTH entries); the core drains
// it at one byte per cycle while it is idle. Every 64 bytes the core leaves
// idle for the round loop (80 rounds, one per cycle) and the chaining add,
// and takes nothing from the queue until both are done. At message end the
// core fills padding one byte per cycle, runs one or two compressions and
// sends the digest, one word per cycle while tready is high.
// A stalled output holds the core in its send step; the queue keeps taking
// input until it is full, then tready drops.
// Reset empties the queue, loads the initial vector and clears the byte
// and bit counts; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sha1_message_digest
    import sha1md_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // byte_value
    input  logic        s_axis_tuser,   // byte_present
    input  logic        s_axis_tlast,   // message_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic [2:0]  m_axis_tuser,   // word_number
    output logic        m_axis_tlast    // digest_last
);

    logic  q_full;
    logic  q_push;
    item_t q_push_item;
    logic  q_pop;
    logic  q_valid;
    item_t q_pop_item;

    sha1md_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (q_push_item)
    );

    sha1md_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (q_pop_item)
    );

    sha1md_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_pop_item),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

FILE: rtl/sha1md_front.sv
// ----------------------------------------------------------------------------
// sha1md_front
// Input side: takes stream transactions, classifies them and pushes the ones
// that do work into the queue toward the hash core.
// ----------------------------------------------------------------------------
module sha1md_front
    import sha1md_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // byte_value
    input  logic       s_axis_tuser,   // byte_present
    input  logic       s_axis_tlast,   // message_end
    input  logic       q_full,
    output logic       q_push,
    output item_t      q_item
);

    logic accept;

    assign s_axis_tready = ~q_full;
    assign accept        = s_axis_tvalid & s_axis_tready;

    // a transaction with neither byte nor end has no effect and is dropped
    assign q_push = accept & (s_axis_tuser | s_axis_tlast);

    always_comb
    begin
        q_item.data = s_axis_tdata;
        unique case ({s_axis_tuser, s_axis_tlast})
            2'b10:   q_item.kind = KIND_BYTE;
            2'b11:   q_item.kind = KIND_BYTE_END;
            default: q_item.kind = KIND_END;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
    else $error("front pushed into a full queue");

endmodule

FILE: rtl/sha1md_queue.sv
// ----------------------------------------------------------------------------
// sha1md_queue
// Short first-in first-out queue of classified transactions between the
// input side and the hash core.
// ----------------------------------------------------------------------------
module sha1md_queue
    import sha1md_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  pop_valid,
    output item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];
    assign do_push   = push & ~full;
    assign do_pop    = pop & pop_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
    else $error("queue count above depth");

endmodule

FILE: rtl/sha1md_core.sv
// ----------------------------------------------------------------------------
// sha1md_core
// Hash core: packs bytes into the block buffer, pads the message, runs the
// 80 rounds one per cycle and sends out the digest words.
// ----------------------------------------------------------------------------
module sha1md_core
    import sha1md_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // digest_word
    output logic [2:0]  m_axis_tuser,  // word_number
    output logic        m_axis_tlast   // digest_last
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_ZFILL,
        ST_EMIT
    } state_t;

    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [5:0] FILL_LAST = 6'd63;
    localparam logic [6:0] RND_LAST  = 7'd79;
    localparam logic [2:0] WORD_LAST = 3'(WORD_COUNT - 1);

    state_t      state_reg;
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;
    logic [6:0]  rnd_reg;
    logic [2:0]  word_reg;
    logic        end_pend_reg;
    logic        pad_done_reg;
    logic        last_blk_reg;
    logic [31:0] h_reg [WORD_COUNT];
    logic [31:0] v_reg [WORD_COUNT];
    logic [31:0] buf_reg [16];
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic [2:0]  out_num_reg;
    logic        out_last_reg;

    logic        has_byte;
    logic        has_end;
    logic        byte_we;
    logic [7:0]  byte_val;
    logic [3:0]  byte_idx;
    logic [4:0]  byte_sh;
    logic [31:0] byte_word;
    logic        len_we;
    logic        start_cmp;
    logic        out_free;
    logic [1:0]  grp;
    logic [31:0] f_val;
    logic [31:0] t_val;
    logic [31:0] w_new;

    assign has_byte = (q_item.kind != KIND_END);
    assign has_end  = (q_item.kind != KIND_BYTE);
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign out_free = !out_valid_reg || m_axis_tready;

    // byte insertion into the block buffer, big-endian within each word
    always_comb
    begin
        byte_we  = 1'b0;
        byte_val = 8'h00;
        case (state_reg)
            ST_IDLE:
            begin
                byte_we  = q_valid && has_byte;
                byte_val = q_item.data;
            end
            ST_PAD:
            begin
                byte_we  = 1'b1;
                byte_val = PAD_BYTE;
            end
            ST_ZFILL:
            begin
                byte_we = (fill_reg != LEN_POS);
            end
            default:
            begin
                byte_we = 1'b0;
            end
        endcase
    end

    assign byte_idx = fill_reg[5:2];
    assign byte_sh  = {~fill_reg[1:0], 3'b000};
    assign byte_word = (fill_reg[1:0] == 2'd0)
        ? ({24'h0, byte_val} << byte_sh)
        : ((buf_reg[byte_idx] & ~(32'hFF << byte_sh)) | ({24'h0, byte_val} << byte_sh));

    assign len_we = (state_reg == ST_ZFILL) && (fill_reg == LEN_POS);

    // a compression starts when the block buffer gets its last byte
    always_comb
    begin
        start_cmp = 1'b0;
        case (state_reg)
            ST_IDLE:  start_cmp = q_valid && has_byte && (fill_reg == FILL_LAST);
            ST_PAD:   start_cmp = (fill_reg == FILL_LAST);
            ST_ZFILL: start_cmp = (fill_reg == FILL_LAST) || (fill_reg == LEN_POS);
            default:  start_cmp = 1'b0;
        endcase
    end

    // one round
    always_comb
    begin
        if (rnd_reg < 7'd20)
        begin
            grp = 2'd0;
        end
        else if (rnd_reg < 7'd40)
        begin
            grp = 2'd1;
        end
        else if (rnd_reg < 7'd60)
        begin
            grp = 2'd2;
        end
        else
        begin
            grp = 2'd3;
        end
        case (grp)
            2'd0:    f_val = (v_reg[1] & v_reg[2]) | (~v_reg[1] & v_reg[3]);
            2'd2:    f_val = (v_reg[1] & v_reg[2]) | (v_reg[1] & v_reg[3])
                           | (v_reg[2] & v_reg[3]);
            default: f_val = v_reg[1] ^ v_reg[2] ^ v_reg[3];
        endcase
    end

    assign t_val = {v_reg[0][26:0], v_reg[0][31:27]} + f_val + v_reg[4]
                 + round_k(grp) + buf_reg[0];
    // schedule word w[i] from the 16-word window w[i-16..i-1]
    assign w_new = buf_reg[13] ^ buf_reg[8] ^ buf_reg[2] ^ buf_reg[0];

    // block buffer doubles as the schedule window during the rounds
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                buf_reg[i] <= buf_reg[i+1];
            end
            buf_reg[15] <= {w_new[30:0], w_new[31]};
            v_reg[0]    <= t_val;
            v_reg[1]    <= v_reg[0];
            v_reg[2]    <= {v_reg[1][1:0], v_reg[1][31:2]};
            v_reg[3]    <= v_reg[2];
            v_reg[4]    <= v_reg[3];
        end
        else
        begin
            if (byte_we)
            begin
                buf_reg[byte_idx] <= byte_word;
            end
            if (len_we)
            begin
                buf_reg[14] <= bits_reg[63:32];
                buf_reg[15] <= bits_reg[31:0];
            end
            if (start_cmp)
            begin
                for (int i = 0; i < WORD_COUNT; i++)
                begin
                    v_reg[i] <= h_reg[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            bits_reg      <= '0;
            rnd_reg       <= '0;
            word_reg      <= '0;
            end_pend_reg  <= 1'b0;
            pad_done_reg  <= 1'b0;
            last_blk_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_num_reg   <= '0;
            out_last_reg  <= 1'b0;
            for (int i = 0; i < WORD_COUNT; i++)
            begin
                h_reg[i] <= SHA1_IV[i];
            end
        end
        else
        begin
            // the send step reloads the output register itself
            if (out_valid_reg && m_axis_tready && (state_reg != ST_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            if (start_cmp)
            begin
                rnd_reg <= '0;
            end
            if (byte_we)
            begin
                fill_reg <= fill_reg + 6'd1;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (has_byte)
                        begin
                            bits_reg <= bits_reg + 64'd8;
                        end
                        end_pend_reg <= has_end;
                        if (start_cmp)
                        begin
                            state_reg <= ST_ROUND;
                        end
                        else if (has_end)
                        begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_PAD:
                begin
                    pad_done_reg <= 1'b1;
                    state_reg    <= start_cmp ? ST_ROUND : ST_ZFILL;
                end
                ST_ZFILL:
                begin
                    if (len_we)
                    begin
                        last_blk_reg <= 1'b1;
                    end
                    if (start_cmp)
                    begin
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND:
                begin
                    rnd_reg <= rnd_reg + 7'd1;
                    if (rnd_reg == RND_LAST)
                    begin
                        state_reg <= ST_FOLD;
                    end
                end
                ST_FOLD:
                begin
                    for (int i = 0; i < WORD_COUNT; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    if (last_blk_reg)
                    begin
                        word_reg  <= '0;
                        state_reg <= ST_EMIT;
                    end
                    else if (end_pend_reg)
                    begin
                        state_reg <= pad_done_reg ? ST_ZFILL : ST_PAD;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= h_reg[word_reg];
                        out_num_reg   <= word_reg;
                        out_last_reg  <= (word_reg == WORD_LAST);
                        word_reg      <= word_reg + 3'd1;
                        if (word_reg == WORD_LAST)
                        begin
                            for (int i = 0; i < WORD_COUNT; i++)
                            begin
                                h_reg[i] <= SHA1_IV[i];
                            end
                            fill_reg     <= '0;
                            bits_reg     <= '0;
                            end_pend_reg <= 1'b0;
                            pad_done_reg <= 1'b0;
                            last_blk_reg <= 1'b0;
                            state_reg    <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_num_reg;
    assign m_axis_tlast  = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (rnd_reg <= RND_LAST))
    else $error("round counter out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (out_num_reg == WORD_LAST))
    else $error("last flag on a word other than the final one");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FOLD) |=> (fill_reg == '0 || fill_reg == LEN_POS))
    else $error("block buffer not at a block boundary after compression");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (fill_reg == LEN_POS))
    else $error("digest sent with padding incomplete");

endmodule
